/* rtl/lsed_pkg.sv */
// ----------------------------------------------------------------------------
// lsed_pkg
// Types, constants, fixed-point helpers and the sequencer microcode for the
// lead self-energy decimation block.
// ----------------------------------------------------------------------------
package lsed_pkg;

  localparam int unsigned FXW       = 64;
  localparam int unsigned REG_AW    = 5;
  localparam int unsigned SRC_W     = 6;
  localparam int unsigned PC_W      = 7;
  localparam int unsigned DIV_STEPS = 112;
  localparam int unsigned DCNT_W    = 7;

  localparam logic [FXW-1:0] SIGN_BIT = {1'b1, {(FXW-1){1'b0}}};
  localparam logic [FXW-1:0] POS_MAX  = {1'b0, {(FXW-1){1'b1}}};
  localparam logic [FXW-1:0] FX_ONE   = 64'h0001_0000_0000_0000;

  // configuration register indexes
  localparam logic [1:0] CFG_ONSITE  = 2'd0;
  localparam logic [1:0] CFG_HOPPING = 2'd1;
  localparam logic [1:0] CFG_TOL     = 2'd2;

  localparam logic [63:0] ONSITE_RST  = 64'h0;
  localparam logic [63:0] HOPPING_RST = 64'hFFFF_0000_0000_0000;
  localparam logic [62:0] TOL_RST     = 63'd2814749767107;

  typedef struct packed {
    logic signed [63:0] energy_re;
    logic signed [63:0] energy_im;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] sigma_re;
    logic signed [63:0] sigma_im;
    logic signed [63:0] green_re;
    logic signed [63:0] green_im;
    logic               converged;
    logic [6:0]         iteration_count;
    logic               overflow;
  } out_item_t;

  // result of a saturating operation
  typedef struct packed {
    logic [FXW-1:0] val;
    logic           ovf;
  } fx_res_t;

  // status of a multi-cycle arithmetic unit
  typedef struct packed {
    logic done;
    logic ovf;
  } unit_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_WAIT
  } seq_state_t;

  typedef enum logic [4:0] {
    OP_MOV,
    OP_ADD,
    OP_SUB,
    OP_SUBX,
    OP_MUL,
    OP_DIV,
    OP_SEL,
    OP_JMP,
    OP_CALL,
    OP_RET,
    OP_BGE,
    OP_INC,
    OP_DIF0,
    OP_DIF1,
    OP_BCV,
    OP_OUTA,
    OP_OUTB
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [REG_AW-1:0] dst;
    logic [SRC_W-1:0]  sa;
    logic [SRC_W-1:0]  sb;
    logic [PC_W-1:0]   tgt;
  } uop_t;

  // scratch register file sources (bit 5 clear); complex divide operands
  // sit at 0..3 so that a swap flips bit 0
  localparam logic [SRC_W-1:0] R_ARE  = 6'd0;
  localparam logic [SRC_W-1:0] R_AIM  = 6'd1;
  localparam logic [SRC_W-1:0] R_BRE  = 6'd2;
  localparam logic [SRC_W-1:0] R_BIM  = 6'd3;
  localparam logic [SRC_W-1:0] R_QRE  = 6'd4;
  localparam logic [SRC_W-1:0] R_QIM  = 6'd5;
  localparam logic [SRC_W-1:0] R_R    = 6'd6;
  localparam logic [SRC_W-1:0] R_X    = 6'd7;
  localparam logic [SRC_W-1:0] R_Y    = 6'd8;
  localparam logic [SRC_W-1:0] R_DEN  = 6'd9;
  localparam logic [SRC_W-1:0] R_TRE  = 6'd10;
  localparam logic [SRC_W-1:0] R_TIM  = 6'd11;
  localparam logic [SRC_W-1:0] R_PRE  = 6'd12;
  localparam logic [SRC_W-1:0] R_PIM  = 6'd13;
  localparam logic [SRC_W-1:0] R_SRE  = 6'd14;
  localparam logic [SRC_W-1:0] R_SIM  = 6'd15;
  localparam logic [SRC_W-1:0] R_DRE  = 6'd16;
  localparam logic [SRC_W-1:0] R_DIM  = 6'd17;
  localparam logic [SRC_W-1:0] R_VRE  = 6'd18;
  localparam logic [SRC_W-1:0] R_VIM  = 6'd19;
  localparam logic [SRC_W-1:0] R_T2RE = 6'd20;
  localparam logic [SRC_W-1:0] R_T2IM = 6'd21;
  localparam logic [SRC_W-1:0] R_Z    = 6'd22;
  localparam logic [SRC_W-1:0] R_H2   = 6'd23;

  // special sources (bit 5 set)
  localparam logic [SRC_W-1:0] S_ZERO = 6'h20;
  localparam logic [SRC_W-1:0] S_ONE  = 6'h21;
  localparam logic [SRC_W-1:0] S_HOP  = 6'h22;
  localparam logic [SRC_W-1:0] S_ONS  = 6'h23;
  localparam logic [SRC_W-1:0] S_ERE  = 6'h24;
  localparam logic [SRC_W-1:0] S_EIM  = 6'h25;

  localparam logic [2:0] SP_ZERO = 3'd0;
  localparam logic [2:0] SP_ONE  = 3'd1;
  localparam logic [2:0] SP_HOP  = 3'd2;
  localparam logic [2:0] SP_ONS  = 3'd3;
  localparam logic [2:0] SP_ERE  = 3'd4;
  localparam logic [2:0] SP_EIM  = 3'd5;

  // microcode labels
  localparam logic [PC_W-1:0] L_LOOP  = 7'd15;
  localparam logic [PC_W-1:0] L_FINAL = 7'd47;
  localparam logic [PC_W-1:0] L_CDIV  = 7'd60;
  localparam logic [PC_W-1:0] L_CZERO = 7'd71;
  localparam logic [PC_W-1:0] L_NONE  = 7'd0;

  function automatic logic [FXW-1:0] fx_mag(input logic [FXW-1:0] x);
    return x[FXW-1] ? (~x + 64'd1) : x;
  endfunction

  function automatic fx_res_t fx_pack(input logic neg, input logic hi_nz,
                                      input logic [FXW-1:0] m);
    fx_res_t r;
    logic [FXW-1:0] limit;
    limit = neg ? SIGN_BIT : POS_MAX;
    if (hi_nz || (m > limit)) begin
      r.ovf = 1'b1;
      r.val = neg ? SIGN_BIT : POS_MAX;
    end else begin
      r.ovf = 1'b0;
      r.val = neg ? (~m + 64'd1) : m;
    end
    return r;
  endfunction

  function automatic fx_res_t fx_add(input logic [FXW-1:0] a, input logic [FXW-1:0] b);
    fx_res_t r;
    logic [FXW-1:0] s;
    s = a + b;
    if ((a[FXW-1] == b[FXW-1]) && (s[FXW-1] != a[FXW-1])) begin
      r.ovf = 1'b1;
      r.val = a[FXW-1] ? SIGN_BIT : POS_MAX;
    end else begin
      r.ovf = 1'b0;
      r.val = s;
    end
    return r;
  endfunction

  function automatic fx_res_t fx_sub(input logic [FXW-1:0] a, input logic [FXW-1:0] b);
    fx_res_t r;
    logic [FXW-1:0] s;
    s = a - b;
    if ((a[FXW-1] != b[FXW-1]) && (s[FXW-1] != a[FXW-1])) begin
      r.ovf = 1'b1;
      r.val = a[FXW-1] ? SIGN_BIT : POS_MAX;
    end else begin
      r.ovf = 1'b0;
      r.val = s;
    end
    return r;
  endfunction

  // exact unsigned magnitude of a signed difference
  function automatic logic [FXW-1:0] fx_absdiff(input logic [FXW-1:0] a,
                                                input logic [FXW-1:0] b);
    return ((a ^ SIGN_BIT) >= (b ^ SIGN_BIT)) ? (a - b) : (b - a);
  endfunction

  function automatic uop_t mk(input op_t op, input logic [SRC_W-1:0] d,
                              input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b,
                              input logic [PC_W-1:0] t);
    uop_t u;
    u.op  = op;
    u.dst = d[REG_AW-1:0];
    u.sa  = a;
    u.sb  = b;
    u.tgt = t;
    return u;
  endfunction

  // sequencer program
  function automatic uop_t urom(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      // d = E - onsite, t = hop / d
      7'd0:  u = mk(OP_SUB,  R_DRE,  S_ERE,  S_ONS,  L_NONE);
      7'd1:  u = mk(OP_MOV,  R_DIM,  S_EIM,  S_ZERO, L_NONE);
      7'd2:  u = mk(OP_MOV,  R_ARE,  S_HOP,  S_ZERO, L_NONE);
      7'd3:  u = mk(OP_MOV,  R_AIM,  S_ZERO, S_ZERO, L_NONE);
      7'd4:  u = mk(OP_MOV,  R_BRE,  R_DRE,  S_ZERO, L_NONE);
      7'd5:  u = mk(OP_MOV,  R_BIM,  R_DIM,  S_ZERO, L_NONE);
      7'd6:  u = mk(OP_CALL, R_ARE,  S_ZERO, S_ZERO, L_CDIV);
      7'd7:  u = mk(OP_MOV,  R_TRE,  R_QRE,  S_ZERO, L_NONE);
      7'd8:  u = mk(OP_MOV,  R_TIM,  R_QIM,  S_ZERO, L_NONE);
      7'd9:  u = mk(OP_MOV,  R_PRE,  R_QRE,  S_ZERO, L_NONE);
      7'd10: u = mk(OP_MOV,  R_PIM,  R_QIM,  S_ZERO, L_NONE);
      7'd11: u = mk(OP_MOV,  R_SRE,  R_QRE,  S_ZERO, L_NONE);
      7'd12: u = mk(OP_MOV,  R_SIM,  R_QIM,  S_ZERO, L_NONE);
      7'd13: u = mk(OP_MOV,  R_VRE,  S_ZERO, S_ZERO, L_NONE);
      7'd14: u = mk(OP_MOV,  R_VIM,  S_ZERO, S_ZERO, L_NONE);
      // loop top: stop at the cap
      7'd15: u = mk(OP_BGE,  R_ARE,  S_ZERO, S_ZERO, L_FINAL);
      // t2 = t * t
      7'd16: u = mk(OP_MUL,  R_X,    R_TRE,  R_TRE,  L_NONE);
      7'd17: u = mk(OP_MUL,  R_Y,    R_TIM,  R_TIM,  L_NONE);
      7'd18: u = mk(OP_SUB,  R_T2RE, R_X,    R_Y,    L_NONE);
      7'd19: u = mk(OP_MUL,  R_X,    R_TRE,  R_TIM,  L_NONE);
      7'd20: u = mk(OP_MUL,  R_Y,    R_TIM,  R_TRE,  L_NONE);
      7'd21: u = mk(OP_ADD,  R_T2IM, R_X,    R_Y,    L_NONE);
      // t = t2 / (1 - 2 t2)
      7'd22: u = mk(OP_ADD,  R_X,    R_T2RE, R_T2RE, L_NONE);
      7'd23: u = mk(OP_SUB,  R_BRE,  S_ONE,  R_X,    L_NONE);
      7'd24: u = mk(OP_ADD,  R_X,    R_T2IM, R_T2IM, L_NONE);
      7'd25: u = mk(OP_SUB,  R_BIM,  S_ZERO, R_X,    L_NONE);
      7'd26: u = mk(OP_MOV,  R_ARE,  R_T2RE, S_ZERO, L_NONE);
      7'd27: u = mk(OP_MOV,  R_AIM,  R_T2IM, S_ZERO, L_NONE);
      7'd28: u = mk(OP_CALL, R_ARE,  S_ZERO, S_ZERO, L_CDIV);
      7'd29: u = mk(OP_MOV,  R_TRE,  R_QRE,  S_ZERO, L_NONE);
      7'd30: u = mk(OP_MOV,  R_TIM,  R_QIM,  S_ZERO, L_NONE);
      // prod = t * prod
      7'd31: u = mk(OP_MUL,  R_X,    R_TRE,  R_PRE,  L_NONE);
      7'd32: u = mk(OP_MUL,  R_Y,    R_TIM,  R_PIM,  L_NONE);
      7'd33: u = mk(OP_SUB,  R_Z,    R_X,    R_Y,    L_NONE);
      7'd34: u = mk(OP_MUL,  R_X,    R_TRE,  R_PIM,  L_NONE);
      7'd35: u = mk(OP_MUL,  R_Y,    R_TIM,  R_PRE,  L_NONE);
      7'd36: u = mk(OP_ADD,  R_PIM,  R_X,    R_Y,    L_NONE);
      7'd37: u = mk(OP_MOV,  R_PRE,  R_Z,    S_ZERO, L_NONE);
      // T += prod, then change test
      7'd38: u = mk(OP_ADD,  R_SRE,  R_SRE,  R_PRE,  L_NONE);
      7'd39: u = mk(OP_ADD,  R_SIM,  R_SIM,  R_PIM,  L_NONE);
      7'd40: u = mk(OP_INC,  R_ARE,  S_ZERO, S_ZERO, L_NONE);
      7'd41: u = mk(OP_DIF0, R_ARE,  R_SRE,  R_VRE,  L_NONE);
      7'd42: u = mk(OP_DIF1, R_ARE,  R_SIM,  R_VIM,  L_NONE);
      7'd43: u = mk(OP_MOV,  R_VRE,  R_SRE,  S_ZERO, L_NONE);
      7'd44: u = mk(OP_MOV,  R_VIM,  R_SIM,  S_ZERO, L_NONE);
      7'd45: u = mk(OP_BCV,  R_ARE,  S_ZERO, S_ZERO, L_FINAL);
      7'd46: u = mk(OP_JMP,  R_ARE,  S_ZERO, S_ZERO, L_LOOP);
      // g = 1 / (d - hop*T), sigma = hop^2 * g
      7'd47: u = mk(OP_MUL,  R_X,    S_HOP,  R_SRE,  L_NONE);
      7'd48: u = mk(OP_SUB,  R_BRE,  R_DRE,  R_X,    L_NONE);
      7'd49: u = mk(OP_MUL,  R_X,    S_HOP,  R_SIM,  L_NONE);
      7'd50: u = mk(OP_SUB,  R_BIM,  R_DIM,  R_X,    L_NONE);
      7'd51: u = mk(OP_MOV,  R_ARE,  S_ONE,  S_ZERO, L_NONE);
      7'd52: u = mk(OP_MOV,  R_AIM,  S_ZERO, S_ZERO, L_NONE);
      7'd53: u = mk(OP_CALL, R_ARE,  S_ZERO, S_ZERO, L_CDIV);
      7'd54: u = mk(OP_MUL,  R_H2,   S_HOP,  S_HOP,  L_NONE);
      7'd55: u = mk(OP_MUL,  R_X,    R_H2,   R_QRE,  L_NONE);
      7'd56: u = mk(OP_MUL,  R_Y,    R_H2,   R_QIM,  L_NONE);
      7'd57: u = mk(OP_OUTA, R_ARE,  R_X,    R_Y,    L_NONE);
      7'd58: u = mk(OP_OUTB, R_ARE,  R_QRE,  R_QIM,  L_NONE);
      // complex divide Q = A / B (Smith), operands swapped by the select step
      7'd60: u = mk(OP_SEL,  R_ARE,  R_BRE,  R_BIM,  L_CZERO);
      7'd61: u = mk(OP_DIV,  R_R,    R_BIM,  R_BRE,  L_NONE);
      7'd62: u = mk(OP_MUL,  R_X,    R_BIM,  R_R,    L_NONE);
      7'd63: u = mk(OP_ADD,  R_DEN,  R_BRE,  R_X,    L_NONE);
      7'd64: u = mk(OP_MUL,  R_X,    R_AIM,  R_R,    L_NONE);
      7'd65: u = mk(OP_ADD,  R_Y,    R_ARE,  R_X,    L_NONE);
      7'd66: u = mk(OP_DIV,  R_QRE,  R_Y,    R_DEN,  L_NONE);
      7'd67: u = mk(OP_MUL,  R_X,    R_ARE,  R_R,    L_NONE);
      7'd68: u = mk(OP_SUBX, R_Y,    R_AIM,  R_X,    L_NONE);
      7'd69: u = mk(OP_DIV,  R_QIM,  R_Y,    R_DEN,  L_NONE);
      7'd70: u = mk(OP_RET,  R_ARE,  S_ZERO, S_ZERO, L_NONE);
      7'd71: u = mk(OP_MOV,  R_QRE,  S_ZERO, S_ZERO, L_NONE);
      7'd72: u = mk(OP_MOV,  R_QIM,  S_ZERO, S_ZERO, L_NONE);
      7'd73: u = mk(OP_RET,  R_ARE,  S_ZERO, S_ZERO, L_NONE);
      default: u = mk(OP_JMP, R_ARE, S_ZERO, S_ZERO, L_FINAL);
    endcase
    return u;
  endfunction

endpackage

/* rtl/lead_self_energy_decimation.sv */
// ----------------------------------------------------------------------------
// lead_self_energy_decimation
// Lead self-energy of a 1D chain by decimation, run by a microcoded sequencer
// over a scratch register file, a shared multiplier and a shared divider.
// ----------------------------------------------------------------------------
// Each decimation iteration holds three divides, eleven multiplies and some
// thirty register moves, adds and control micro-ops on the one datapath.
// Throughput: one energy point at a time; busy stays high until the result.
// The result shows for one cycle on out_valid; the receiver cannot stall.
// Reset (synchronous, rst_n low) returns to idle and reloads register defaults.
// ----------------------------------------------------------------------------
module lead_self_energy_decimation
  import lsed_pkg::*;
#(
  parameter int unsigned MAX_ITER = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [63:0] cfg_wdata
);

  localparam int unsigned IW = $clog2(MAX_ITER + 1);
  localparam logic [IW-1:0] ITER_CAP = IW'(MAX_ITER);

  // configuration
  logic [63:0] onsite_r;
  logic [63:0] hopping_r;
  logic [62:0] tol_r;

  // sequencer state
  seq_state_t      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [PC_W-1:0] ret_r, ret_nxt;
  logic            swap_r, swap_nxt;
  logic [IW-1:0]   iter_r, iter_nxt;
  logic            conv_r, conv_nxt;
  logic            ovf_r, ovf_nxt;
  logic [FXW-1:0]  dmax_r, dmax_nxt;
  in_item_t        in_r, in_nxt;
  logic [FXW-1:0]  sig_re_r, sig_re_nxt;
  logic [FXW-1:0]  sig_im_r, sig_im_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  uop_t              uop;
  logic [REG_AW-1:0] rd_addr_a, rd_addr_b;
  logic [FXW-1:0]    rd_data_a, rd_data_b;
  logic [FXW-1:0]    opa, opb;
  logic              wr_en;
  logic [FXW-1:0]    wr_data;
  logic              mul_start, div_start;
  unit_stat_t        mul_stat, div_stat;
  logic [FXW-1:0]    mul_result, div_result;

  function automatic logic [REG_AW-1:0] remap(input logic [REG_AW-1:0] a,
                                              input logic sw);
    if (sw && (a[REG_AW-1:2] == '0)) begin
      return {a[REG_AW-1:1], ~a[0]};
    end
    return a;
  endfunction

  function automatic logic [FXW-1:0] special(input logic [2:0] code,
                                             input logic [63:0] hop,
                                             input logic [63:0] ons,
                                             input in_item_t e);
    case (code)
      SP_ZERO: return '0;
      SP_ONE:  return FX_ONE;
      SP_HOP:  return hop;
      SP_ONS:  return ons;
      SP_ERE:  return e.energy_re;
      SP_EIM:  return e.energy_im;
      default: return '0;
    endcase
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      onsite_r  <= ONSITE_RST;
      hopping_r <= HOPPING_RST;
      tol_r     <= TOL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ONSITE:  onsite_r  <= cfg_wdata;
        CFG_HOPPING: hopping_r <= cfg_wdata;
        CFG_TOL:     tol_r     <= cfg_wdata[62:0];
        default: ;
      endcase
    end
  end

  // decode current micro-op and operand sources
  assign uop       = urom(pc_r);
  assign rd_addr_a = remap(uop.sa[REG_AW-1:0], swap_r);
  assign rd_addr_b = remap(uop.sb[REG_AW-1:0], swap_r);
  assign opa = uop.sa[SRC_W-1] ? special(uop.sa[2:0], hopping_r, onsite_r, in_r) : rd_data_a;
  assign opb = uop.sb[SRC_W-1] ? special(uop.sb[2:0], hopping_r, onsite_r, in_r) : rd_data_b;

  lsed_ram #(
    .WIDTH (FXW),
    .DEPTH (32)
  ) u_regfile (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (uop.dst),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  lsed_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (opa),
    .b      (opb),
    .stat   (mul_stat),
    .result (mul_result)
  );

  lsed_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .x      (opa),
    .y      (opb),
    .stat   (div_stat),
    .result (div_result)
  );

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      ret_r       <= '0;
      swap_r      <= 1'b0;
      iter_r      <= '0;
      conv_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      ret_r       <= ret_nxt;
      swap_r      <= swap_nxt;
      iter_r      <= iter_nxt;
      conv_r      <= conv_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dmax_r     <= dmax_nxt;
    in_r       <= in_nxt;
    sig_re_r   <= sig_re_nxt;
    sig_im_r   <= sig_im_nxt;
    out_data_r <= out_data_nxt;
  end

  // next state and micro-op execution
  always_comb begin
    fx_res_t        alu;
    logic [FXW-1:0] dim;
    logic [FXW-1:0] dm;
    unit_stat_t     ust;

    state_nxt     = state_r;
    pc_nxt        = pc_r;
    ret_nxt       = ret_r;
    swap_nxt      = swap_r;
    iter_nxt      = iter_r;
    conv_nxt      = conv_r;
    ovf_nxt       = ovf_r;
    dmax_nxt      = dmax_r;
    in_nxt        = in_r;
    sig_re_nxt    = sig_re_r;
    sig_im_nxt    = sig_im_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_data       = opa;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    alu           = '0;
    dim           = fx_absdiff(opa, opb);
    dm            = (dim > dmax_r) ? dim : dmax_r;
    ust           = (uop.op == OP_MUL) ? mul_stat : div_stat;

    case (state_r)
      // take a new energy point
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_FETCH;
          pc_nxt    = '0;
          iter_nxt  = '0;
          conv_nxt  = 1'b0;
          ovf_nxt   = 1'b0;
          swap_nxt  = 1'b0;
          in_nxt    = in_data;
        end
      end

      // register file read in flight
      ST_FETCH: begin
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        state_nxt = ST_FETCH;
        pc_nxt    = pc_r + PC_W'(1);
        case (uop.op)
          OP_MOV: begin
            wr_en = 1'b1;
          end
          OP_ADD: begin
            alu     = fx_add(opa, opb);
            wr_en   = 1'b1;
            wr_data = alu.val;
            ovf_nxt = ovf_r | alu.ovf;
          end
          OP_SUB: begin
            alu     = fx_sub(opa, opb);
            wr_en   = 1'b1;
            wr_data = alu.val;
            ovf_nxt = ovf_r | alu.ovf;
          end
          OP_SUBX: begin
            alu     = swap_r ? fx_sub(opb, opa) : fx_sub(opa, opb);
            wr_en   = 1'b1;
            wr_data = alu.val;
            ovf_nxt = ovf_r | alu.ovf;
          end
          OP_MUL: begin
            mul_start = 1'b1;
            state_nxt = ST_WAIT;
            pc_nxt    = pc_r;
          end
          OP_DIV: begin
            div_start = 1'b1;
            state_nxt = ST_WAIT;
            pc_nxt    = pc_r;
          end
          // divide by the larger part; zero divisor gives zero
          OP_SEL: begin
            if ((opa == '0) && (opb == '0)) begin
              ovf_nxt = 1'b1;
              pc_nxt  = uop.tgt;
            end else begin
              swap_nxt = fx_mag(opa) < fx_mag(opb);
            end
          end
          OP_JMP: begin
            pc_nxt = uop.tgt;
          end
          OP_CALL: begin
            ret_nxt = pc_r + PC_W'(1);
            pc_nxt  = uop.tgt;
          end
          OP_RET: begin
            pc_nxt   = ret_r;
            swap_nxt = 1'b0;
          end
          OP_BGE: begin
            if (iter_r >= ITER_CAP) begin
              pc_nxt = uop.tgt;
            end
          end
          OP_INC: begin
            iter_nxt = iter_r + IW'(1);
          end
          OP_DIF0: begin
            dmax_nxt = dim;
          end
          OP_DIF1: begin
            if (dm <= {1'b0, tol_r}) begin
              conv_nxt = 1'b1;
            end
          end
          OP_BCV: begin
            if (conv_r) begin
              pc_nxt = uop.tgt;
            end
          end
          OP_OUTA: begin
            sig_re_nxt = opa;
            sig_im_nxt = opb;
          end
          // emit the result and drop back to idle
          OP_OUTB: begin
            state_nxt                    = ST_IDLE;
            out_valid_nxt                = 1'b1;
            out_data_nxt.sigma_re        = sig_re_r;
            out_data_nxt.sigma_im        = sig_im_r;
            out_data_nxt.green_re        = opa;
            out_data_nxt.green_im        = opb;
            out_data_nxt.converged       = conv_r;
            out_data_nxt.iteration_count = (32'(iter_r) > 32'd127) ? 7'd127 : 7'(iter_r);
            out_data_nxt.overflow        = ovf_r;
          end
          default: ;
        endcase
      end

      // hold until the shared unit finishes, then write back
      ST_WAIT: begin
        if (ust.done) begin
          wr_en     = 1'b1;
          wr_data   = (uop.op == OP_MUL) ? mul_result : div_result;
          ovf_nxt   = ovf_r | ust.ovf;
          pc_nxt    = pc_r + PC_W'(1);
          state_nxt = ST_FETCH;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result pulse is always followed by an idle cycle
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  // the result goes out only after the sequencer returned to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer active");

  // operand swap never leaks out of a complex divide
  a_swap_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !swap_r)
    else $error("operand swap left set in idle");

  // the shared units never finish together
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_stat.done, div_stat.done}))
    else $error("multiplier and divider finished in the same cycle");

  // iteration count never passes the cap
  a_iter_cap: assert property (@(posedge clk) disable iff (!rst_n)
    iter_r <= ITER_CAP)
    else $error("iteration count beyond cap");

endmodule

/* rtl/lsed_ram.sv */
// ----------------------------------------------------------------------------
// lsed_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lsed_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rd_data_a <= mem_r[rd_addr_a];
    rd_data_b <= mem_r[rd_addr_b];
  end

endmodule

/* rtl/lsed_mul.sv */
// ----------------------------------------------------------------------------
// lsed_mul
// Saturating Q16.48 multiplier built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module lsed_mul
  import lsed_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [FXW-1:0] a,
  input  logic [FXW-1:0] b,
  output unit_stat_t     stat,
  output logic [FXW-1:0] result
);

  localparam logic [2:0] LAST_STEP = 3'd5;

  logic           active_r;
  logic [2:0]     step_r;
  logic [FXW-1:0] ua_r;
  logic [FXW-1:0] ub_r;
  logic           neg_r;
  logic [63:0]    pp_r;
  logic [127:0]   acc_r;
  logic [63:0]    pp_nxt;
  logic [127:0]   pp_sh;
  fx_res_t        packed_res;

  // pick the partial product for this step
  always_comb begin
    case (step_r)
      3'd0:    pp_nxt = 64'(ua_r[31:0])  * 64'(ub_r[31:0]);
      3'd1:    pp_nxt = 64'(ua_r[31:0])  * 64'(ub_r[63:32]);
      3'd2:    pp_nxt = 64'(ua_r[63:32]) * 64'(ub_r[31:0]);
      3'd3:    pp_nxt = 64'(ua_r[63:32]) * 64'(ub_r[63:32]);
      default: pp_nxt = 64'd0;
    endcase
  end

  // align the previous partial product
  always_comb begin
    case (step_r)
      3'd1:    pp_sh = 128'(pp_r);
      3'd2:    pp_sh = 128'(pp_r) << 32;
      3'd3:    pp_sh = 128'(pp_r) << 32;
      3'd4:    pp_sh = 128'(pp_r) << 64;
      default: pp_sh = 128'd0;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= 3'd0;
    end else if (start) begin
      active_r <= 1'b1;
      step_r   <= 3'd0;
    end else if (active_r) begin
      if (step_r == LAST_STEP) begin
        active_r <= 1'b0;
      end else begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      ua_r  <= fx_mag(a);
      ub_r  <= fx_mag(b);
      neg_r <= a[FXW-1] ^ b[FXW-1];
      acc_r <= 128'd0;
    end else if (active_r) begin
      pp_r  <= pp_nxt;
      acc_r <= acc_r + pp_sh;
    end
  end

  // truncate to Q16.48 and saturate
  assign packed_res = fx_pack(neg_r, acc_r[127:112] != 16'd0, acc_r[111:48]);
  assign result     = packed_res.val;
  assign stat.done  = active_r && (step_r == LAST_STEP);
  assign stat.ovf   = packed_res.ovf;

endmodule

/* rtl/lsed_div.sv */
// ----------------------------------------------------------------------------
// lsed_div
// Saturating Q16.48 divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsed_div
  import lsed_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [FXW-1:0] x,
  input  logic [FXW-1:0] y,
  output unit_stat_t     stat,
  output logic [FXW-1:0] result
);

  localparam logic [DCNT_W-1:0] STEPS = DCNT_W'(DIV_STEPS);

  logic                 active_r;
  logic [DCNT_W-1:0]    cnt_r;
  logic                 zero_r;
  logic                 neg_r;
  logic [DIV_STEPS-1:0] nq_r;
  logic [FXW-1:0]       rem_r;
  logic [FXW-1:0]       uy_r;
  logic [FXW:0]         rem_sh;
  logic                 qbit;
  logic [FXW-1:0]       rem_nxt;
  logic                 finish;
  fx_res_t              packed_res;

  // one restoring step
  always_comb begin
    rem_sh = {rem_r, nq_r[DIV_STEPS-1]};
    qbit   = rem_sh >= {1'b0, uy_r};
    if (qbit) begin
      rem_nxt = FXW'(rem_sh - {1'b0, uy_r});
    end else begin
      rem_nxt = rem_sh[FXW-1:0];
    end
  end

  assign finish = active_r && (zero_r || (cnt_r == STEPS));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (start) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (finish) begin
      active_r <= 1'b0;
    end else if (active_r) begin
      cnt_r <= cnt_r + DCNT_W'(1);
    end
  end

  // shift numerator out, quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (y == '0);
      neg_r  <= x[FXW-1] ^ y[FXW-1];
      nq_r   <= {fx_mag(x), 48'd0};
      rem_r  <= '0;
      uy_r   <= fx_mag(y);
    end else if (active_r && !finish) begin
      nq_r  <= {nq_r[DIV_STEPS-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign packed_res = fx_pack(neg_r, nq_r[DIV_STEPS-1:FXW] != '0, nq_r[FXW-1:0]);
  assign result     = zero_r ? '0 : packed_res.val;
  assign stat.done  = finish;
  assign stat.ovf   = zero_r | packed_res.ovf;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the lead self-energy decimation block against a fixed-point predictor
// of the decimation loop. Directed energy points and register settings come
// first, then random points in phases with and without gaps on the sender.
// ----------------------------------------------------------------------------
module tb;
  import lsed_pkg::*;

  localparam int unsigned ITER_CAP = 64;
  localparam longint unsigned CYCLE_LIMIT = 64'd200_000_000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic [63:0] re;
    logic [63:0] im;
  } cx_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [63:0] cfg_wdata;

  // predictor copy of the registers
  logic [63:0] onsite_q;
  logic [63:0] hop_q;
  logic [63:0] tol_q;
  bit          sat_seen;

  out_item_t   pending_results[$];
  int unsigned mismatch_count;
  longint unsigned cycle_count;

  lead_self_energy_decimation #(.MAX_ITER(ITER_CAP)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] sat_pack(input bit neg, input bit hi_nz,
                                           input logic [63:0] m);
    logic [63:0] lim;
    lim = neg ? SIGN_BIT : POS_MAX;
    if (hi_nz || m > lim) begin
      sat_seen = 1'b1;
      return lim;
    end
    return neg ? (64'd0 - m) : m;
  endfunction

  function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      sat_seen = 1'b1;
      return a[63] ? SIGN_BIT : POS_MAX;
    end
    return s;
  endfunction

  function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) begin
      sat_seen = 1'b1;
      return a[63] ? SIGN_BIT : POS_MAX;
    end
    return s;
  endfunction

  function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    p = p >> 48;
    return sat_pack(a[63] ^ b[63], |p[127:64], p[63:0]);
  endfunction

  function automatic logic [63:0] q_div(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] q;
    if (y == 64'd0) begin
      sat_seen = 1'b1;
      return 64'd0;
    end
    q = {16'd0, mag64(x), 48'd0} / {64'd0, mag64(y)};
    return sat_pack(x[63] ^ y[63], |q[127:64], q[63:0]);
  endfunction

  function automatic cx_t cx_mul(input cx_t a, input cx_t b);
    cx_t r;
    r.re = q_sub(q_mul(a.re, b.re), q_mul(a.im, b.im));
    r.im = q_add(q_mul(a.re, b.im), q_mul(a.im, b.re));
    return r;
  endfunction

  // Smith's method: divide by the larger part of the divisor
  function automatic cx_t cx_div(input cx_t a, input cx_t b);
    cx_t q;
    logic [63:0] r, den;
    if (b.re == 64'd0 && b.im == 64'd0) begin
      sat_seen = 1'b1;
      q.re = 64'd0;
      q.im = 64'd0;
      return q;
    end
    if (mag64(b.re) >= mag64(b.im)) begin
      r = q_div(b.im, b.re);
      den = q_add(b.re, q_mul(b.im, r));
      q.re = q_div(q_add(a.re, q_mul(a.im, r)), den);
      q.im = q_div(q_sub(a.im, q_mul(a.re, r)), den);
    end else begin
      r = q_div(b.re, b.im);
      den = q_add(b.im, q_mul(b.re, r));
      q.re = q_div(q_add(q_mul(a.re, r), a.im), den);
      q.im = q_div(q_sub(q_mul(a.im, r), a.re), den);
    end
    return q;
  endfunction

  function automatic logic [63:0] change_mag(input logic [63:0] a, input logic [63:0] b);
    return ((a ^ SIGN_BIT) >= (b ^ SIGN_BIT)) ? (a - b) : (b - a);
  endfunction

  function automatic out_item_t predict_point(input in_item_t pt);
    out_item_t   r;
    cx_t         d, t, t2, onem, prod, tsum, prev, hop, den, unit, g;
    logic [63:0] dmax, dim, h2;
    int unsigned iters;
    bit          conv;
    sat_seen = 1'b0;
    iters = 0;
    conv = 1'b0;
    d.re = q_sub(pt.energy_re, onsite_q);
    d.im = pt.energy_im;
    hop.re = hop_q;
    hop.im = 64'd0;
    t = cx_div(hop, d);
    prod = t;
    tsum = t;
    prev.re = 64'd0;
    prev.im = 64'd0;
    // decimate until the transfer sum settles or the cap is hit
    while (iters < ITER_CAP) begin
      t2 = cx_mul(t, t);
      onem.re = q_sub(FX_ONE, q_add(t2.re, t2.re));
      onem.im = q_sub(64'd0, q_add(t2.im, t2.im));
      t = cx_div(t2, onem);
      prod = cx_mul(t, prod);
      tsum.re = q_add(tsum.re, prod.re);
      tsum.im = q_add(tsum.im, prod.im);
      iters++;
      dmax = change_mag(tsum.re, prev.re);
      dim = change_mag(tsum.im, prev.im);
      if (dim > dmax) dmax = dim;
      prev = tsum;
      if (dmax <= tol_q) begin
        conv = 1'b1;
        break;
      end
    end
    den.re = q_sub(d.re, q_mul(hop_q, tsum.re));
    den.im = q_sub(d.im, q_mul(hop_q, tsum.im));
    unit.re = FX_ONE;
    unit.im = 64'd0;
    g = cx_div(unit, den);
    h2 = q_mul(hop_q, hop_q);
    r.sigma_re = q_mul(h2, g.re);
    r.sigma_im = q_mul(h2, g.im);
    r.green_re = g.re;
    r.green_im = g.im;
    r.converged = conv;
    r.iteration_count = (iters > 127) ? 7'd127 : iters[6:0];
    r.overflow = sat_seen;
    return r;
  endfunction

  // ------------------------------------------------------------------ checker
  task automatic report(input string field, input logic [63:0] got,
                        input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    mismatch_count++;
  endtask

  task automatic cmp_field(input string field, input logic [63:0] got,
                           input logic [63:0] want);
    if (got !== want) report(field, got, want);
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_data.sigma_re, 64'd0);
      end else begin
        want = pending_results.pop_front();
        cmp_field("sigma_re", out_data.sigma_re, want.sigma_re);
        cmp_field("sigma_im", out_data.sigma_im, want.sigma_im);
        cmp_field("green_re", out_data.green_re, want.green_re);
        cmp_field("green_im", out_data.green_im, want.green_im);
        cmp_field("converged", 64'(out_data.converged), 64'(want.converged));
        cmp_field("iteration_count", 64'(out_data.iteration_count),
                  64'(want.iteration_count));
        cmp_field("overflow", 64'(out_data.overflow), 64'(want.overflow));
      end
    end
  end

  // end the run if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL lead_self_energy_decimation");
      $finish;
    end
  end

  // ----------------------------------------------------------------- drivers
  task automatic send_point(input logic [63:0] e_re, input logic [63:0] e_im,
                            input int unsigned idle_pct);
    in_item_t pt;
    pt.energy_re = e_re;
    pt.energy_im = e_im;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    in_data = pt;
    // hold until the transfer
    do @(posedge clk); while (busy);
    pending_results.insert(pending_results.size(), predict_point(pt));
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    case (idx)
      CFG_ONSITE:  onsite_q = val;
      CFG_HOPPING: hop_q = val;
      CFG_TOL:     tol_q = {1'b0, val[62:0]};
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // energy within about 2.5 of the band center, small positive broadening
  function automatic logic [63:0] band_re();
    return 64'(longint'($urandom_range(327680)) - 64'sd163840) <<< 32;
  endfunction

  function automatic logic [63:0] band_im();
    return 64'($urandom_range(13107, 655)) << 32;
  endfunction

  // ------------------------------------------------------------------- tests
  task automatic test_field_extremes();
    send_point(64'd0, 64'd0, 0);                 // zero divisor
    send_point(POS_MAX, 64'd0, 0);
    send_point(SIGN_BIT, 64'd0, 0);
    send_point(64'd0, POS_MAX, 0);
    send_point(64'd0, SIGN_BIT, 0);
    send_point(SIGN_BIT, SIGN_BIT, 0);
    send_point(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 0);
    send_point(FX_ONE << 1, 64'd0, 0);           // band edge
    send_point(FX_ONE >> 1, FX_ONE >> 6, 0);
    send_point(band_re(), band_im(), 0);
    drain();
  endtask

  task automatic test_iteration_cap();
    // zero tolerance forces the cap inside the band
    write_reg(CFG_TOL, 64'd0);
    send_point(FX_ONE >> 2, FX_ONE >> 8, 0);
    send_point(band_re(), band_im(), 0);
    drain();
    write_reg(CFG_TOL, 64'hFFFF_FFFF_FFFF_FFFF);  // largest tolerance
    send_point(band_re(), band_im(), 0);
    send_point(64'd0, 64'd0, 0);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_HOPPING, 64'd0);
    send_point(band_re(), band_im(), 0);
    drain();
    write_reg(CFG_HOPPING, POS_MAX);
    write_reg(CFG_ONSITE, SIGN_BIT);
    send_point(band_re(), band_im(), 0);
    send_point(SIGN_BIT, 64'd0, 0);              // energy equals onsite
    drain();
    write_reg(CFG_HOPPING, SIGN_BIT);
    write_reg(CFG_ONSITE, POS_MAX);
    write_reg(CFG_TOL, 64'd2814749767107);
    send_point(POS_MAX, 64'd0, 0);
    send_point(SIGN_BIT, band_im(), 0);
    drain();
    // out-of-range index must be ignored
    write_reg(CFG_UNUSED, rand64());
    write_reg(CFG_ONSITE, FX_ONE >> 3);
    write_reg(CFG_HOPPING, 64'd0 - FX_ONE);
    send_point(FX_ONE >> 3, 64'd0, 0);
    send_point(band_re(), band_im(), 0);
    drain();
  endtask

  task automatic test_random_points(input int unsigned count, input int unsigned idle_pct);
    int unsigned pick;
    // fresh register setting for each phase
    write_reg(CFG_ONSITE, ($urandom_range(3) == 0) ? rand64() : band_re());
    write_reg(CFG_HOPPING, ($urandom_range(7) == 0) ? rand64()
                                                     : (64'd0 - FX_ONE) + band_re());
    write_reg(CFG_TOL, ($urandom_range(3) == 0) ? rand64()
                                                 : {$urandom, $urandom} >> $urandom_range(40, 20));
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 85) send_point(rand64(), rand64(), idle_pct);
      else if (pick < 97) send_point(onsite_q + band_re(), band_im(), idle_pct);
      else send_point(onsite_q, 64'd0, idle_pct);
    end
    drain();
  endtask

  // ------------------------------------------------------------------- main
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_ONSITE;
    cfg_wdata = 64'd0;
    onsite_q = ONSITE_RST;
    hop_q = HOPPING_RST;
    tol_q = {1'b0, TOL_RST};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_iteration_cap();
    test_register_extremes();
    for (int unsigned ph = 0; ph < 4; ph++) test_random_points(70, 0);
    for (int unsigned ph = 0; ph < 4; ph++) test_random_points(70, 59);
    for (int unsigned ph = 0; ph < 4; ph++) test_random_points(70, 24);
    test_random_points(90, $urandom_range(1) ? 0 : 59);

    drain();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS lead_self_energy_decimation");
    end else begin
      $display("FAIL lead_self_energy_decimation");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lsed_pkg.sv
rtl/lsed_ram.sv
rtl/lsed_mul.sv
rtl/lsed_div.sv
rtl/lead_self_energy_decimation.sv
test/tb.sv
